FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the divider checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an asynchronous active-low reset that disables it.
`define RUD_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same check, with the project clock and reset names.
`define RUD_ASSERT(label, prop, msg) \
	`RUD_ASSERT_RST(label, clk, arst_n, prop, msg)

`endif

FILE: sv/rud_pkg.sv
// ----------------------------------------------------------------------------
// Divider package
// Widths and the item type that travels down the row of division cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rud_pkg;

	// Width of the ports' data fields.
	localparam int DATA_W = 32;

	// Width of the division; one cell per quotient bit.
	localparam int WIDTH = 32;

	// Quotient reported for a zero divisor: all ones in WIDTH bits.
	localparam logic [DATA_W-1:0] DBZ_QUOTIENT = DATA_W'({WIDTH{1'b1}});

	// State of one item between two cells. The quotient register starts as the
	// dividend and takes one quotient bit in at its bottom per cell.
	typedef struct packed {
		logic [WIDTH-1:0] quo;
		logic [WIDTH-1:0] rem;
		logic [WIDTH-1:0] dvs;
	} stage_t;

endpackage

`default_nettype wire

FILE: sv/rud_in_if.sv
// ----------------------------------------------------------------------------
// Divider operand channel
// Valid/ready channel that carries one dividend and divisor per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rud_in_if import rud_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] dividend;
	logic [DATA_W-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink (input valid, input dividend, input divisor, output ready);
endinterface

`default_nettype wire

FILE: sv/rud_out_if.sv
// ----------------------------------------------------------------------------
// Divider result channel
// Valid/ready channel that carries one quotient and remainder per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rud_out_if import rud_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] quotient;
	logic [DATA_W-1:0] remainder;
	logic              divide_by_zero;

	modport source (output valid, output quotient, output remainder,
		output divide_by_zero, input ready);
	modport sink (input valid, input quotient, input remainder,
		input divide_by_zero, output ready);
endinterface

`default_nettype wire

FILE: sv/rud_cell.sv
// ----------------------------------------------------------------------------
// Division cell
// One restoring step: shift in a dividend bit, trial subtract, keep or restore.
// ----------------------------------------------------------------------------
`default_nettype none

module rud_cell import rud_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire stage_t in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output stage_t      out_data
);

	logic          valid_q;
	stage_t        data_q;
	stage_t        step_d;
	logic [WIDTH:0] trial;

	// The shifted remainder is WIDTH+1 bits: the old remainder above the next
	// dividend bit. A borrow out of the subtraction means restore.
	always_comb begin
		trial      = {in_data.rem, in_data.quo[WIDTH-1]} - {1'b0, in_data.dvs};
		step_d.dvs = in_data.dvs;
		step_d.quo = {in_data.quo[WIDTH-2:0], ~trial[WIDTH]};
		if (trial[WIDTH]) begin
			step_d.rem = {in_data.rem[WIDTH-2:0], in_data.quo[WIDTH-1]};
		end else begin
			step_d.rem = trial[WIDTH-1:0];
		end
	end

	// The cell takes a new item when it is empty or its item moves on.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= step_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

FILE: sv/restoring_unsigned_divider_top.sv
// ----------------------------------------------------------------------------
// Restoring unsigned divider
// Pipelined array divider built from a row of restoring division cells.
// ----------------------------------------------------------------------------
// Divides an unsigned dividend by an unsigned divisor and returns quotient and
// remainder. The divider is a row of WIDTH cells, one per quotient bit, each
// with its own register, so a new item is taken in every cycle while results
// are accepted; each item passes through all WIDTH cell registers in order.
// Each cell holds its item until the next cell can take it, so a stall on the
// result side fills empty cells first and operands are still accepted while
// any cell is free. A zero divisor gives a quotient of all ones, the dividend
// as remainder, and sets divide_by_zero.
`default_nettype none

module restoring_unsigned_divider_top import rud_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rud_in_if.sink    operands,
	rud_out_if.source results
);

	logic   chain_valid [WIDTH+1];
	logic   chain_ready [WIDTH+1];
	stage_t chain_data  [WIDTH+1];

	// Entry of the row: the remainder starts at zero, the quotient register
	// holds the dividend.
	assign chain_valid[0]    = operands.valid;
	assign operands.ready    = chain_ready[0];
	assign chain_data[0].quo = WIDTH'(operands.dividend);
	assign chain_data[0].rem = '0;
	assign chain_data[0].dvs = WIDTH'(operands.divisor);

	// One cell per quotient bit.
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		rud_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	// The last cell's register is the output register.
	assign results.valid          = chain_valid[WIDTH];
	assign chain_ready[WIDTH]     = results.ready;
	assign results.quotient       = DATA_W'(chain_data[WIDTH].quo);
	assign results.remainder      = DATA_W'(chain_data[WIDTH].rem);
	assign results.divide_by_zero = (chain_data[WIDTH].dvs == '0);

endmodule

`default_nettype wire

FILE: sv/rud_checker.sv
// ----------------------------------------------------------------------------
// Divider checker
// Port-level assertions for the restoring divider, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rud_checker import rud_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [DATA_W-1:0] quotient,
	input wire logic [DATA_W-1:0] remainder,
	input wire logic              divide_by_zero
);

	// A stalled result stays offered.
	`RUD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// A stalled result keeps its value.
	`RUD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({quotient, remainder, divide_by_zero}), "result changed while stalled")

	// With no result waiting, the last cell has room, so operands are taken.
	`RUD_ASSERT(a_in_ready, !out_valid |-> in_ready, "operands refused with an empty output")

	// A zero divisor leaves every trial subtraction successful.
	`RUD_ASSERT(a_dbz_quo, out_valid && divide_by_zero |-> quotient == DBZ_QUOTIENT, "bad quotient for a zero divisor")

endmodule

bind restoring_unsigned_divider_top rud_checker u_rud_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (operands.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.quotient       (results.quotient),
	.remainder      (results.remainder),
	.divide_by_zero (results.divide_by_zero)
);

`default_nettype wire

FILE: dv/tb_restoring_unsigned_divider_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Restoring unsigned divider testbench
// Drives operand pairs into the pipelined divider and checks every quotient,
// remainder and divide-by-zero flag against a bit-level restoring division
// computed here. Directed corner cases come first, then random pairs under
// four idling phases on the operand and result channels.
// ----------------------------------------------------------------------------

module tb_restoring_unsigned_divider_top;
	import rud_pkg::*;

	// One pair of operands waiting to be sent.
	typedef struct {
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} operand_pair_t;

	// One division outcome as the result channel carries it.
	typedef struct {
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
		logic              divide_by_zero;
	} division_t;

	localparam int RANDOM_PER_PHASE = 333;
	localparam int STALL_LIMIT      = 4000;
	localparam int DRAIN_CYCLES     = 2 * WIDTH + 8;

	logic clk;
	logic arst_n;

	rud_in_if  operands_if ();
	rud_out_if results_if ();

	operand_pair_t operand_queue[$];
	division_t     expected_divisions[$];
	int            send_idle_pct;
	int            recv_stall_pct;
	int            mismatches;
	int            quiet_cycles;

	restoring_unsigned_divider_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_if),
		.results  (results_if)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Textbook restoring division over WIDTH bits with a WIDTH+1 bit partial
	// remainder, so divisors with the top bit set are handled correctly.
	function automatic division_t divide_restoring(logic [DATA_W-1:0] dividend,
		logic [DATA_W-1:0] divisor);
		logic [WIDTH-1:0] dvd;
		logic [WIDTH-1:0] dvs;
		logic [WIDTH-1:0] quo;
		logic [WIDTH:0]   part;
		division_t        res;
		dvd = WIDTH'(dividend);
		dvs = WIDTH'(divisor);
		quo = dvd;
		part = '0;
		for (int i = 0; i < WIDTH; i++) begin
			part = {part[WIDTH-1:0], quo[WIDTH-1]};
			quo = quo << 1;
			if (part >= {1'b0, dvs}) begin
				part = part - {1'b0, dvs};
				quo[0] = 1'b1;
			end
		end
		res.quotient = DATA_W'(quo);
		res.remainder = DATA_W'(part[WIDTH-1:0]);
		res.divide_by_zero = (dvs == '0);
		return res;
	endfunction

	task automatic queue_division(logic [DATA_W-1:0] dividend, logic [DATA_W-1:0] divisor);
		operand_pair_t pair;
		pair.dividend = dividend;
		pair.divisor = divisor;
		operand_queue.push_back(pair);
	endtask

	// Random operand pairs, weighted toward the interesting corners: short and
	// zero divisors, divisors with the top bit set, small dividends, exact
	// multiples.
	task automatic queue_random_divisions(int count);
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
		int                kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			dividend = DATA_W'($urandom);
			divisor = DATA_W'($urandom);
			case (kind)
				4, 5: begin
					divisor = divisor >> $urandom_range(1, DATA_W - 1);
				end
				6: begin
					divisor = '0;
				end
				7: begin
					divisor[DATA_W-1] = 1'b1;
				end
				8: begin
					dividend = divisor >> $urandom_range(0, DATA_W - 1);
				end
				9: begin
					divisor = DATA_W'($urandom_range(1, 65535));
					dividend = divisor * DATA_W'($urandom_range(0, 65535));
				end
				default: begin
				end
			endcase
			queue_division(dividend, divisor);
		end
	endtask

	task automatic wait_queue_empty();
		while (operand_queue.size() != 0)
			@(posedge clk);
	endtask

	// Operand driver: presents the next pending pair whenever the channel is
	// free, unless the current phase makes the sender idle this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operands_if.valid <= 1'b0;
			operands_if.dividend <= '0;
			operands_if.divisor <= '0;
		end else if (!operands_if.valid || operands_if.ready) begin
			if (operand_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				operands_if.valid <= 1'b1;
				operands_if.dividend <= operand_queue[0].dividend;
				operands_if.divisor <= operand_queue[0].divisor;
				void'(operand_queue.pop_front());
			end else begin
				operands_if.valid <= 1'b0;
			end
		end
	end

	// Result-side back pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Every accepted operand pair adds its expected division.
	always @(posedge clk) begin
		if (arst_n && operands_if.valid && operands_if.ready) begin
			expected_divisions.push_back(divide_restoring(operands_if.dividend,
				operands_if.divisor));
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_divisions.size() == 0) begin
				$error("unexpected result: quotient %h remainder %h divide_by_zero %b",
					results_if.quotient, results_if.remainder, results_if.divide_by_zero);
				mismatches++;
			end else begin
				if (results_if.quotient !== expected_divisions[0].quotient) begin
					$error("quotient: expected %h, actual %h",
						expected_divisions[0].quotient, results_if.quotient);
					mismatches++;
				end
				if (results_if.remainder !== expected_divisions[0].remainder) begin
					$error("remainder: expected %h, actual %h",
						expected_divisions[0].remainder, results_if.remainder);
					mismatches++;
				end
				if (results_if.divide_by_zero !== expected_divisions[0].divide_by_zero) begin
					$error("divide_by_zero: expected %b, actual %b",
						expected_divisions[0].divide_by_zero, results_if.divide_by_zero);
					mismatches++;
				end
				void'(expected_divisions.pop_front());
			end
		end
	end

	// Watchdog: ends the run when neither channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (operands_if.valid && operands_if.ready)
			|| (results_if.valid && results_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("tb_restoring_unsigned_divider_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		operands_if.valid = 1'b0;
		operands_if.dividend = '0;
		operands_if.divisor = '0;
		results_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners: zero divisor, unit divisor, extremes, divisors with
		// the top bit set, dividend below, equal to and above the divisor.
		queue_division('0, '0);
		queue_division('1, '0);
		queue_division(32'h1234_5678, '0);
		queue_division('0, 32'd1);
		queue_division('1, 32'd1);
		queue_division('1, '1);
		queue_division(32'd1, '1);
		queue_division(32'hFFFF_FFFE, '1);
		queue_division(32'h8000_0000, 32'h8000_0000);
		queue_division(32'h7FFF_FFFF, 32'h8000_0000);
		queue_division('1, 32'h8000_0001);
		queue_division('1, 32'd2);
		queue_division(32'h8000_0000, 32'd1);
		queue_division(32'd5, 32'd7);
		queue_division(32'd7, 32'd5);
		queue_division(32'd100, 32'd10);
		queue_division(32'h1234_5678, 32'h0000_1234);
		queue_division(32'h5555_5555, 32'hAAAA_AAAA);
		queue_division(32'hAAAA_AAAA, 32'h5555_5555);
		queue_division(32'hDEAD_BEEF, 32'hDEAD_BEEF);
		queue_division('0, '1);
		wait_queue_empty();

		// Random pairs under each idling phase; the first has no idling at all.
		queue_random_divisions(RANDOM_PER_PHASE);
		wait_queue_empty();
		send_idle_pct = 64;
		recv_stall_pct = 0;
		queue_random_divisions(RANDOM_PER_PHASE);
		wait_queue_empty();
		send_idle_pct = 0;
		recv_stall_pct = 64;
		queue_random_divisions(RANDOM_PER_PHASE);
		wait_queue_empty();
		send_idle_pct = 21;
		recv_stall_pct = 21;
		queue_random_divisions(RANDOM_PER_PHASE);

		// Drain: all pairs accepted, all results seen, then a final wait for stray results.
		while (operand_queue.size() != 0 || operands_if.valid
			|| expected_divisions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_divisions.size() == 0) begin
			$display("tb_restoring_unsigned_divider_top: PASS");
		end else begin
			$display("tb_restoring_unsigned_divider_top: FAIL");
		end
		$finish;
	end

endmodule
